/* design/bayer_gradient_corrected_demosaic_macros.svh */
// Assertion macros shared by the demosaic design.
`ifndef BAYER_GRADIENT_CORRECTED_DEMOSAIC_MACROS_SVH
`define BAYER_GRADIENT_CORRECTED_DEMOSAIC_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BGCD_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("demosaic same-cycle check failed");

// Implication whose consequence is checked in the next cycle.
`define BGCD_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("demosaic next-cycle check failed");

`endif

/* design/bgcd_pkg.sv */
package bgcd_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int MIN_SIZE   = 5;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int WID_W = COL_W + 1;
   localparam int HGT_W = ROW_W + 1;

   localparam int CFG_WIDTH_BITS  = 11;
   localparam int CFG_HEIGHT_BITS = 13;
   localparam logic [CFG_WIDTH_BITS-1:0]  WIDTH_RESET  = CFG_WIDTH_BITS'(390);
   localparam logic [CFG_HEIGHT_BITS-1:0] HEIGHT_RESET = CFG_HEIGHT_BITS'(300);

   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int REG_INDEX_BIT = 2;

   localparam int PIX_W     = 8;
   localparam int KSIZE     = 5;
   localparam int ROWS_KEPT = 5;
   localparam int SLOT_W    = $clog2(ROWS_KEPT);

   // Input command codes.
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   // Register indexes.
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   typedef logic [PIX_W-1:0] pix_type;
   // One window column, element k is row offset k-2.
   typedef pix_type [KSIZE-1:0] col_type;
   // Five columns, element 2 is the center column, element 4 the newest.
   typedef col_type [KSIZE-1:0] hist_type;

   // Position of the output pixel as the kernel logic needs it.
   typedef struct packed {
      logic row_odd;
      logic col_odd;
      logic left0;
      logic left1;
      logic right0;
      logic right1;
   } pos_type;

endpackage

/* design/bgcd_ram.sv */
module bgcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/bgcd_kernel.sv */
module bgcd_kernel (
   input  bgcd_pkg::hist_type hist,
   input  bgcd_pkg::pos_type  pos,
   output bgcd_pkg::pix_type  red,
   output bgcd_pkg::pix_type  green,
   output bgcd_pkg::pix_type  blue
);
   import bgcd_pkg::*;

   localparam int SUM_W = 16;
   typedef logic signed [SUM_W-1:0] sum_type;

   pix_type win [KSIZE][KSIZE];
   sum_type ctr, diag, hz, vt, g_rb, opp;
   pix_type hz_px, vt_px, g_px, opp_px;
   logic    red_row;

   function automatic sum_type sx(input pix_type v);
      return sum_type'({1'b0, v});
   endfunction

   // Weighted sums carry sixteen times the result; round half up and saturate.
   function automatic pix_type scale16(input sum_type s);
      sum_type v;
      v = (s + sum_type'(8)) >>> 4;
      if (s <= 0) begin
         return '0;
      end else if (v > sum_type'(255)) begin
         return '1;
      end
      return pix_type'(v);
   endfunction

   // Replicate the edge columns by choosing which stored column feeds each tap.
   always_comb begin
      logic [2:0] idx;
      for (int dx = 0; dx < KSIZE; dx++) begin
         idx = 3'(dx);
         if (pos.left0 && dx < 2) begin
            idx = 3'd2;
         end else if (pos.left1 && dx == 0) begin
            idx = 3'd1;
         end
         if (pos.right0 && dx > 2) begin
            idx = 3'd2;
         end else if (pos.right1 && dx == 4) begin
            idx = 3'd3;
         end
         for (int dy = 0; dy < KSIZE; dy++) begin
            win[dy][dx] = hist[idx][dy];
         end
      end
   end

   always_comb begin
      ctr  = sx(win[2][2]);
      diag = sx(win[1][1]) + sx(win[1][3]) + sx(win[3][1]) + sx(win[3][3]);
      hz   = sum_type'(10) * ctr - (diag <<< 1)
           + ((sx(win[2][1]) + sx(win[2][3])) <<< 3)
           - ((sx(win[2][0]) + sx(win[2][4])) <<< 1)
           + sx(win[0][2]) + sx(win[4][2]);
      vt   = sum_type'(10) * ctr - (diag <<< 1)
           + ((sx(win[1][2]) + sx(win[3][2])) <<< 3)
           - ((sx(win[0][2]) + sx(win[4][2])) <<< 1)
           + sx(win[2][0]) + sx(win[2][4]);
      g_rb = (ctr <<< 3)
           + ((sx(win[1][2]) + sx(win[3][2]) + sx(win[2][1]) + sx(win[2][3])) <<< 2)
           - ((sx(win[0][2]) + sx(win[4][2]) + sx(win[2][0]) + sx(win[2][4])) <<< 1);
      opp  = sum_type'(12) * ctr + (diag <<< 2)
           - sum_type'(3) * (sx(win[0][2]) + sx(win[4][2]) + sx(win[2][0]) + sx(win[2][4]));
   end

   assign hz_px  = scale16(hz);
   assign vt_px  = scale16(vt);
   assign g_px   = scale16(g_rb);
   assign opp_px = scale16(opp);
   assign red_row = !pos.row_odd;

   always_comb begin
      if (pos.row_odd == pos.col_odd) begin
         // Green site: the color sharing this row takes the horizontal kernel.
         red   = red_row ? hz_px : vt_px;
         green = win[2][2];
         blue  = red_row ? vt_px : hz_px;
      end else if (red_row) begin
         red   = win[2][2];
         green = g_px;
         blue  = opp_px;
      end else begin
         red   = opp_px;
         green = g_px;
         blue  = win[2][2];
      end
   end

endmodule

/* design/bayer_gradient_corrected_demosaic.sv */
// A result moves through the s1 and s2 registers into the response registers.
// One item per cycle unless the output stalls; each line RAM writes and reads at once.
// Results trail the mosaic by 2*width+2 pixels; flush items drain the rest of the frame.
// Reset is synchronous and active high; it restores the default frame size and
// empties the pipeline. The line store is not cleared and needs no clearing pass.
`include "bayer_gradient_corrected_demosaic_macros.svh"

module bayer_gradient_corrected_demosaic (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [bgcd_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [bgcd_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [bgcd_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_cmd,
   input  bgcd_pkg::pix_type                   req_raw_pixel,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output bgcd_pkg::pix_type                   rsp_red,
   output bgcd_pkg::pix_type                   rsp_green,
   output bgcd_pkg::pix_type                   rsp_blue,
   output logic                                rsp_frame_last
);
   import bgcd_pkg::*;

   logic [CFG_WIDTH_BITS-1:0]  cfg_width_ff;
   logic [CFG_HEIGHT_BITS-1:0] cfg_height_ff;
   logic [WID_W-1:0]           eff_w;
   logic [HGT_W-1:0]           eff_h;
   logic [COL_W-1:0]           last_col;
   logic [ROW_W-1:0]           last_row;
   logic                       csr_wr;
   logic                       csr_index;

   logic [COL_W-1:0]  in_col_ff, in_col_in, fd_col_ff, fd_col_in, out_col_ff, out_col_in;
   logic [ROW_W-1:0]  in_row_ff, in_row_in, fd_row_ff, fd_row_in, out_row_ff, out_row_in;
   logic [SLOT_W-1:0] in_slot_ff, in_slot_in, fd_slot_ff, fd_slot_in;
   logic              draining_ff, draining_in;

   logic adv, acc, is_pix, is_flush, feed, emit, frame_end;
   logic [SLOT_W-1:0] slot_sel [KSIZE];
   pos_type pos0;

   logic              s1_feed_ff, s1_emit_ff, s1_from_pix_ff, s1_last_ff;
   pix_type           s1_pix_ff;
   logic [SLOT_W-1:0] s1_slot_ff [KSIZE];
   pos_type           s1_pos_ff;
   logic              s2_emit_ff, s2_last_ff;
   pos_type           s2_pos_ff;
   hist_type          hist_ff;
   col_type           new_col;

   pix_type rd_data [ROWS_KEPT];
   pix_type k_red, k_green, k_blue;
   logic    rsp_valid_ff, rsp_last_ff;
   pix_type rsp_red_ff, rsp_green_ff, rsp_blue_ff;

   function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
      return (s == SLOT_W'(ROWS_KEPT - 1)) ? '0 : s + 1'b1;
   endfunction

   // ---------------- configuration ----------------
   assign pready    = 1'b1;
   assign csr_wr    = psel && penable && pwrite;
   assign csr_index = paddr[REG_INDEX_BIT];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= WIDTH_RESET;
         cfg_height_ff <= HEIGHT_RESET;
      end else if (csr_wr) begin
         unique case (csr_index)
            REG_WIDTH:  cfg_width_ff  <= pwdata[CFG_WIDTH_BITS-1:0];
            REG_HEIGHT: cfg_height_ff <= pwdata[CFG_HEIGHT_BITS-1:0];
            default:    cfg_width_ff  <= cfg_width_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_WIDTH:  prdata = CSR_DATA_W'(cfg_width_ff);
         REG_HEIGHT: prdata = CSR_DATA_W'(cfg_height_ff);
         default:    prdata = '0;
      endcase
   end

   always_comb begin
      if (32'(cfg_width_ff) < MIN_SIZE) begin
         eff_w = WID_W'(MIN_SIZE);
      end else if (32'(cfg_width_ff) > MAX_WIDTH) begin
         eff_w = WID_W'(MAX_WIDTH);
      end else begin
         eff_w = WID_W'(cfg_width_ff);
      end
      if (32'(cfg_height_ff) < MIN_SIZE) begin
         eff_h = HGT_W'(MIN_SIZE);
      end else if (32'(cfg_height_ff) > MAX_HEIGHT) begin
         eff_h = HGT_W'(MAX_HEIGHT);
      end else begin
         eff_h = HGT_W'(cfg_height_ff);
      end
   end

   assign last_col = COL_W'(eff_w - 1'b1);
   assign last_row = ROW_W'(eff_h - 1'b1);

   // ---------------- input stage ----------------
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign acc       = req_valid && adv;
   assign is_pix    = acc && (req_cmd == CMD_PIXEL) && !draining_ff;
   assign is_flush  = acc && (req_cmd == CMD_FLUSH) && draining_ff;

   // A column of the window enters with every pixel from the third row on, and
   // with every flush item; for a pixel, its bottom sample is the pixel arriving now.
   assign feed = (is_pix && in_row_ff >= ROW_W'(2)) || is_flush;
   assign emit = (is_pix && (in_row_ff > ROW_W'(2) ||
                             (in_row_ff == ROW_W'(2) && in_col_ff >= COL_W'(2))))
                 || is_flush;
   assign frame_end = emit && out_row_ff == last_row && out_col_ff == last_col;

   assign pos0.row_odd = out_row_ff[0];
   assign pos0.col_odd = out_col_ff[0];
   assign pos0.left0   = out_col_ff == '0;
   assign pos0.left1   = out_col_ff == COL_W'(1);
   assign pos0.right0  = out_col_ff == last_col;
   assign pos0.right1  = out_col_ff == last_col - 1'b1;

   // Line-store slot for each row of the entering column, with rows clamped
   // into the frame by replicating the top and bottom lines.
   always_comb begin
      logic signed [3:0]       d;
      logic signed [ROW_W+1:0] gap;
      logic [3:0]              t;
      gap = $signed({2'b00, last_row}) - $signed({2'b00, fd_row_ff});
      for (int k = 0; k < KSIZE; k++) begin
         d = 4'(k - 2);
         if (k < 2 && 32'(fd_row_ff) < 2 - k) begin
            d = -$signed({3'b000, fd_row_ff[0]});
         end else if (k > 2 && gap < k - 2) begin
            d = (gap < -2) ? -4'sd2 : 4'(gap);
         end
         t = 4'({1'b0, fd_slot_ff}) + 4'(d + 5);
         if (t >= 4'd10) begin
            t = t - 4'd10;
         end else if (t >= 4'd5) begin
            t = t - 4'd5;
         end
         slot_sel[k] = SLOT_W'(t);
      end
   end

   always_comb begin
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      in_slot_in  = in_slot_ff;
      draining_in = draining_ff;
      fd_col_in   = fd_col_ff;
      fd_row_in   = fd_row_ff;
      fd_slot_in  = fd_slot_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      if (is_pix) begin
         if (in_row_ff == last_row && in_col_ff == last_col) begin
            draining_in = 1'b1;
         end else if (in_col_ff == last_col) begin
            in_col_in  = '0;
            in_row_in  = in_row_ff + 1'b1;
            in_slot_in = slot_next(in_slot_ff);
         end else begin
            in_col_in = in_col_ff + 1'b1;
         end
      end
      if (feed) begin
         if (fd_col_ff == last_col) begin
            fd_col_in  = '0;
            fd_row_in  = fd_row_ff + 1'b1;
            fd_slot_in = slot_next(fd_slot_ff);
         end else begin
            fd_col_in = fd_col_ff + 1'b1;
         end
      end
      if (emit) begin
         if (out_col_ff == last_col) begin
            out_col_in = '0;
            out_row_in = out_row_ff + 1'b1;
         end else begin
            out_col_in = out_col_ff + 1'b1;
         end
      end
      // Emitting the final result of a frame, or a register write, starts a new frame.
      if (frame_end || csr_wr) begin
         in_col_in   = '0;
         in_row_in   = '0;
         in_slot_in  = '0;
         draining_in = 1'b0;
         fd_col_in   = '0;
         fd_row_in   = '0;
         fd_slot_in  = '0;
         out_col_in  = '0;
         out_row_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_slot_ff  <= '0;
         draining_ff <= 1'b0;
         fd_col_ff   <= '0;
         fd_row_ff   <= '0;
         fd_slot_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
      end else begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         in_slot_ff  <= in_slot_in;
         draining_ff <= draining_in;
         fd_col_ff   <= fd_col_in;
         fd_row_ff   <= fd_row_in;
         fd_slot_ff  <= fd_slot_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
      end
   end

   // ---------------- line store: one RAM per kept row ----------------
   for (genvar i = 0; i < ROWS_KEPT; i++) begin : g_line
      bgcd_ram #(
         .WIDTH (PIX_W),
         .DEPTH (MAX_WIDTH)
      ) u_line (
         .clock   (clock),
         .wr_en   (is_pix && in_slot_ff == SLOT_W'(i)),
         .wr_addr (in_col_ff),
         .wr_data (req_raw_pixel),
         .rd_en   (adv),
         .rd_addr (fd_col_ff),
         .rd_data (rd_data[i])
      );
   end

   // ---------------- pipeline ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_feed_ff   <= 1'b0;
         s1_emit_ff   <= 1'b0;
         s2_emit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_feed_ff   <= feed;
         s1_emit_ff   <= emit;
         s2_emit_ff   <= s1_emit_ff;
         rsp_valid_ff <= s2_emit_ff;
      end
   end

   always_comb begin
      for (int k = 0; k < KSIZE; k++) begin
         new_col[k] = rd_data[s1_slot_ff[k]];
      end
      if (s1_from_pix_ff) begin
         new_col[KSIZE-1] = s1_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_from_pix_ff <= is_pix;
         s1_pix_ff      <= req_raw_pixel;
         s1_slot_ff     <= slot_sel;
         s1_pos_ff      <= pos0;
         s1_last_ff     <= frame_end;
         s2_pos_ff      <= s1_pos_ff;
         s2_last_ff     <= s1_last_ff;
         if (s1_feed_ff) begin
            for (int i = 0; i < KSIZE - 1; i++) begin
               hist_ff[i] <= hist_ff[i+1];
            end
            hist_ff[KSIZE-1] <= new_col;
         end
         rsp_red_ff   <= k_red;
         rsp_green_ff <= k_green;
         rsp_blue_ff  <= k_blue;
         rsp_last_ff  <= s2_last_ff;
      end
   end

   bgcd_kernel u_kernel (
      .hist  (hist_ff),
      .pos   (s2_pos_ff),
      .red   (k_red),
      .green (k_green),
      .blue  (k_blue)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red        = rsp_red_ff;
   assign rsp_green      = rsp_green_ff;
   assign rsp_blue       = rsp_blue_ff;
   assign rsp_frame_last = rsp_last_ff;

   // ---------------- assertions ----------------
   `BGCD_ASSERT_IMPLY(a_drain_pos, clock, reset, draining_ff, in_row_ff == last_row && in_col_ff == last_col)
   `BGCD_ASSERT_NEXT(a_end_clears, clock, reset, frame_end, out_row_ff == '0 && out_col_ff == '0 && !draining_ff)
   `BGCD_ASSERT_IMPLY(a_slot_range, clock, reset, 1'b1, in_slot_ff <= SLOT_W'(ROWS_KEPT - 1) && fd_slot_ff <= SLOT_W'(ROWS_KEPT - 1))
   `BGCD_ASSERT_IMPLY(a_emit_feeds, clock, reset, emit, feed)

endmodule

/* bench/bayer_gradient_corrected_demosaic_test.sv */
module bayer_gradient_corrected_demosaic_test;
   import bgcd_pkg::*;

   typedef struct packed {
      pix_type red;
      pix_type green;
      pix_type blue;
      logic    frame_last;
   } rgb_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;
   logic req_valid = 1'b0, req_stall, req_cmd = CMD_PIXEL;
   pix_type req_raw_pixel = '0;
   logic rsp_valid, rsp_stall = 1'b0, rsp_frame_last;
   pix_type rsp_red, rsp_green, rsp_blue;

   bayer_gradient_corrected_demosaic dut (.*);

   always #10 clock = ~clock;

   // Predictor state.
   pix_type mosaic_rows [ROWS_KEPT][MAX_WIDTH];
   int cfg_width = 390, cfg_height = 300;
   int in_col, in_row, out_col, out_row;
   bit draining;
   rgb_type pending_pixels [$];
   int mismatches = 0;
   int idle_cycles = 0;
   int gap_level = 3;
   int stall_level = 3;

   function automatic int eff_w();
      return cfg_width < MIN_SIZE ? MIN_SIZE : (cfg_width > MAX_WIDTH ? MAX_WIDTH : cfg_width);
   endfunction

   function automatic int eff_h();
      return cfg_height < MIN_SIZE ? MIN_SIZE
           : (cfg_height > MAX_HEIGHT ? MAX_HEIGHT : cfg_height);
   endfunction

   function automatic pix_type round_clamp(int s);
      int v;
      if (s <= 0) return '0;
      v = (s + 8) >>> 4;
      return v > 255 ? 8'd255 : pix_type'(v);
   endfunction

   // Builds the edge-replicated 5x5 window and applies the gradient-corrected kernels.
   function automatic rgb_type interpolate_pixel();
      int w, h, r, c, rr, cc, s, diag;
      int win [5][5];
      rgb_type o;
      bit red_row;
      int hsum, vsum;
      w = eff_w(); h = eff_h(); r = out_row; c = out_col;
      for (int dy = 0; dy < 5; dy++)
         for (int dx = 0; dx < 5; dx++) begin
            rr = r + dy - 2; cc = c + dx - 2;
            if (rr < 0) rr = 0;
            if (rr > h - 1) rr = h - 1;
            if (cc < 0) cc = 0;
            if (cc > w - 1) cc = w - 1;
            win[dy][dx] = mosaic_rows[rr % ROWS_KEPT][cc];
         end
      diag = win[1][1] + win[1][3] + win[3][1] + win[3][3];
      s = 10 * win[2][2] - 2 * diag;
      hsum = s + 8 * (win[2][1] + win[2][3]) - 2 * (win[2][0] + win[2][4])
           + win[0][2] + win[4][2];
      vsum = s + 8 * (win[1][2] + win[3][2]) - 2 * (win[0][2] + win[4][2])
           + win[2][0] + win[2][4];
      if (((r + c) & 1) == 0) begin
         red_row = (r & 1) == 0;
         o.red = round_clamp(red_row ? hsum : vsum);
         o.green = pix_type'(win[2][2]);
         o.blue = round_clamp(red_row ? vsum : hsum);
      end else begin
         int g, opp;
         g = 8 * win[2][2] + 4 * (win[1][2] + win[3][2] + win[2][1] + win[2][3])
           - 2 * (win[0][2] + win[4][2] + win[2][0] + win[2][4]);
         opp = 12 * win[2][2] + 4 * diag
             - 3 * (win[0][2] + win[4][2] + win[2][0] + win[2][4]);
         o.green = round_clamp(g);
         if ((r & 1) == 0) begin
            o.red = pix_type'(win[2][2]);
            o.blue = round_clamp(opp);
         end else begin
            o.red = round_clamp(opp);
            o.blue = pix_type'(win[2][2]);
         end
      end
      o.frame_last = (r == h - 1) && (c == w - 1);
      if (o.frame_last) begin
         out_row = 0; out_col = 0; in_row = 0; in_col = 0; draining = 0;
      end else if (c + 1 >= w) begin
         out_col = 0; out_row = r + 1;
      end else out_col = c + 1;
      return o;
   endfunction

   function automatic void predict_item(logic cmd, pix_type raw);
      int w, h, p;
      w = eff_w(); h = eff_h();
      if (cmd == CMD_FLUSH) begin
         if (draining) pending_pixels.push_back(interpolate_pixel());
         return;
      end
      if (draining) return;
      mosaic_rows[in_row % ROWS_KEPT][in_col] = raw;
      p = in_row * w + in_col;
      if (in_row == h - 1 && in_col == w - 1) draining = 1;
      else if (in_col + 1 >= w) begin
         in_col = 0; in_row++;
      end else in_col++;
      if (p >= 2 * w + 2) pending_pixels.push_back(interpolate_pixel());
   endfunction

   // Result checker and receiver stall pattern.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            rgb_type got, want;
            got = {rsp_red, rsp_green, rsp_blue, rsp_frame_last};
            if (pending_pixels.size() == 0) begin
               $display("%0t: unexpected pixel %h", $realtime, got);
               mismatches++;
            end else begin
               want = pending_pixels.pop_front();
               if (got.red !== want.red)
                  $display("%0t: red expected %0d actual %0d", $realtime, want.red, got.red);
               if (got.green !== want.green)
                  $display("%0t: green expected %0d actual %0d", $realtime,
                           want.green, got.green);
               if (got.blue !== want.blue)
                  $display("%0t: blue expected %0d actual %0d", $realtime, want.blue, got.blue);
               if (got.frame_last !== want.frame_last)
                  $display("%0t: frame_last expected %0b actual %0b", $realtime,
                           want.frame_last, got.frame_last);
               if (got !== want) mismatches++;
            end
         end
         rsp_stall <= ($urandom_range(9) < stall_level);
      end
   end

   // Watchdog over cycles in which nothing moves.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic send_item(logic cmd, pix_type raw);
      if (gap_level > 0 && $urandom_range(9) < gap_level) begin
         int gap;
         req_valid <= 1'b0;
         gap = $urandom_range(4, 1);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_raw_pixel <= raw;
      do @(posedge clock); while (req_stall);
      predict_item(cmd, raw);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic index, int value);
      settle();
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= CSR_ADDR_W'({index, 2'b00});
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (index == REG_WIDTH) cfg_width = value & 'h7FF;
      else cfg_height = value & 'h1FFF;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0; draining = 0;
      @(posedge clock);
   endtask

   // One full frame; mode 0 random, 1 all zero, 2 all max, 3 alternating 0 and 255 in raster order.
   task automatic send_frame(int mode, int extra_noise);
      int n;
      n = eff_w() * eff_h();
      for (int i = 0; i < n; i++) begin
         pix_type v;
         case (mode)
            0: v = pix_type'($urandom);
            1: v = 8'd0;
            2: v = 8'd255;
            default: v = (i % 2) ? 8'd255 : 8'd0;
         endcase
         if (extra_noise > 0 && $urandom_range(99) < extra_noise)
            send_item(CMD_FLUSH, pix_type'($urandom));
         send_item(CMD_PIXEL, v);
      end
      // Pixels while draining are dropped.
      send_item(CMD_PIXEL, pix_type'($urandom));
      for (int i = 0; i < 2 * eff_w() + 2; i++) send_item(CMD_FLUSH, pix_type'($urandom));
   endtask

   task automatic test_minimum_frames();
      write_reg(REG_WIDTH, 5);
      write_reg(REG_HEIGHT, 5);
      send_item(CMD_FLUSH, 8'd0);
      send_frame(1, 0);
      send_frame(2, 0);
      send_frame(3, 0);
   endtask

   task automatic test_size_saturation();
      write_reg(REG_WIDTH, 0);
      write_reg(REG_HEIGHT, 2);
      send_frame(0, 0);
      // The widest frame yields nothing until two full lines have arrived.
      write_reg(REG_WIDTH, 'h7FF);
      write_reg(REG_HEIGHT, 'h1FFF);
      for (int i = 0; i < 20; i++) send_item(CMD_PIXEL, pix_type'($urandom));
   endtask

   task automatic test_abandoned_frame();
      write_reg(REG_WIDTH, 6);
      write_reg(REG_HEIGHT, 7);
      for (int i = 0; i < 20; i++) send_item(CMD_PIXEL, pix_type'($urandom));
      write_reg(REG_HEIGHT, 6);
      send_frame(0, 0);
   endtask

   task automatic test_random_frames();
      for (int f = 0; f < 2; f++) begin
         gap_level = $urandom_range(4);
         stall_level = $urandom_range(5);
         write_reg(REG_WIDTH, $urandom_range(9, 5));
         write_reg(REG_HEIGHT, $urandom_range(9, 5));
         send_frame(0, 5);
      end
   endtask

   task automatic test_default_reset_size();
      // A few results at the default size, then abandoned by a write.
      for (int i = 0; i < 784; i++) send_item(CMD_PIXEL, pix_type'($urandom));
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_reset_size();
      test_minimum_frames();
      test_size_saturation();
      test_abandoned_frame();
      test_random_frames();
      settle();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_pixels.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
